@@ hdl/krc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krc_pkg
// Shared types and constants for the key register cache with two-bit aging.
// ----------------------------------------------------------------------------
package krc_pkg;

	localparam int CACHE_SLOTS_DEF = 16;
	localparam int FIRST_SLOT_DEF  = 8;

	localparam int KEY_W  = 32;
	localparam int OP_W   = 2;
	localparam int SLOT_W = 5;
	localparam int SUM_W  = SLOT_W + 1;
	localparam int AGE_W  = 2;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic lookup;
		logic capture_victim;
		logic age;
		logic finish;
	} krc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_victim;
		logic cand_any;
		logic out_free;
	} krc_stat_t;

endpackage
`default_nettype wire

@@ hdl/krc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krc_ctrl
// Sequencer: accept, look up, age until a victim shows up, deliver.
// ----------------------------------------------------------------------------
module krc_ctrl
	import krc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire krc_stat_t stat,
	output krc_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = stat.need_victim ? ST_SEARCH : ST_FINISH;
			end
			ST_SEARCH: begin
				// age unused slots until one has its high age bit set
				if (stat.cand_any) begin
					cmd.capture_victim = 1'b1;
					state_d            = ST_FINISH;
				end else begin
					cmd.age = 1'b1;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/krc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krc_dpath
// Slot keys, valid bits, ages and use marks, associative lookup, victim
// search and the output register.
// ----------------------------------------------------------------------------
module krc_dpath
	import krc_pkg::*;
#(
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
	parameter int FIRST_SLOT  = FIRST_SLOT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire krc_cmd_t          cmd,
	output krc_stat_t              stat,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [KEY_W-1:0]  key_addr,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [SLOT_W-1:0]      slot,
	output logic                   hit,
	output logic                   fill_needed,
	output logic                   evict_valid,
	output logic [KEY_W-1:0]       evict_key,
	output logic                   status
);

	localparam int IDX_W = $clog2(CACHE_SLOTS);

	logic [OP_W-1:0]        op_q;
	logic [KEY_W-1:0]       key_q;
	logic [KEY_W-1:0]       slot_key_q [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] slot_valid_q;
	logic [AGE_W-1:0]       slot_age_q [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] used_q;

	logic                   direct_q;
	logic                   hit_q;
	logic                   full_q;
	logic [IDX_W-1:0]       idx_q;

	logic                   out_valid_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   hit_out_q;
	logic                   fill_q;
	logic                   evict_valid_q;
	logic [KEY_W-1:0]       evict_key_q;
	logic                   status_q;

	logic                   is_direct;
	logic                   is_access;
	logic [CACHE_SLOTS-1:0] match_vec;
	logic [CACHE_SLOTS-1:0] cand_vec;
	logic [IDX_W-1:0]       match_idx;
	logic [IDX_W-1:0]       cand_idx;
	logic [SUM_W-1:0]       slot_sum;
	logic [SLOT_W-1:0]      res_slot;
	logic                   res_hit;
	logic                   res_fill;
	logic                   res_evict_valid;
	logic [KEY_W-1:0]       res_evict_key;
	logic                   res_status;

	assign is_direct = key_q < KEY_W'(FIRST_SLOT);
	assign is_access = (op_q == OP_LOAD) || (op_q == OP_STORE);

	always_comb begin
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			match_vec[i] = slot_valid_q[i] && (slot_key_q[i] == key_q);
			cand_vec[i]  = !used_q[i] && slot_age_q[i][AGE_W-1];
		end
	end

	// lowest set bit wins
	always_comb begin
		match_idx = '0;
		cand_idx  = '0;
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (match_vec[i]) match_idx = IDX_W'(i);
			if (cand_vec[i])  cand_idx  = IDX_W'(i);
		end
	end

	assign stat.need_victim = is_access && !is_direct && !(|match_vec) && !(&used_q);
	assign stat.cand_any    = |cand_vec;
	assign stat.out_free    = !out_valid_q || out_ready;

	assign slot_sum = SUM_W'(FIRST_SLOT) + SUM_W'(idx_q);

	always_comb begin
		res_slot        = '0;
		res_hit         = 1'b0;
		res_fill        = 1'b0;
		res_evict_valid = 1'b0;
		res_evict_key   = '0;
		res_status      = 1'b0;
		case (op_q) inside
			OP_LOAD, OP_STORE: begin
				if (direct_q) begin
					res_slot = key_q[SLOT_W-1:0];
					res_hit  = 1'b1;
				end else if (hit_q) begin
					res_slot = slot_sum[SLOT_W-1:0];
					res_hit  = 1'b1;
				end else if (full_q) begin
					res_status = 1'b1;
				end else begin
					res_slot        = slot_sum[SLOT_W-1:0];
					res_fill        = (op_q == OP_LOAD);
					res_evict_valid = slot_valid_q[idx_q];
					res_evict_key   = slot_valid_q[idx_q] ? slot_key_q[idx_q] : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// input and lookup results
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op;
			key_q <= key_addr;
		end
		if (cmd.lookup) begin
			direct_q <= is_direct;
			hit_q    <= |match_vec;
			full_q   <= &used_q;
			idx_q    <= match_idx;
		end else if (cmd.capture_victim) begin
			idx_q <= cand_idx;
		end
	end

	wire victim_write = cmd.finish && is_access && !direct_q && !hit_q && !full_q;

	always_ff @(posedge clk) begin
		if (victim_write) begin
			slot_key_q[idx_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			used_q       <= '0;
			for (int i = 0; i < CACHE_SLOTS; i++) begin
				slot_age_q[i] <= '0;
			end
		end else begin
			if (cmd.age) begin
				// no unused slot has its high bit set here, so no wrap
				for (int i = 0; i < CACHE_SLOTS; i++) begin
					if (!used_q[i]) slot_age_q[i] <= slot_age_q[i] + AGE_W'(1);
				end
			end
			if (cmd.finish) begin
				if (op_q == OP_COMMIT) begin
					for (int i = 0; i < CACHE_SLOTS; i++) begin
						if (used_q[i]) slot_age_q[i] <= '0;
					end
					used_q <= '0;
				end else if (is_access && !direct_q && !full_q) begin
					used_q[idx_q] <= 1'b1;
					if (!hit_q) slot_valid_q[idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			slot_q        <= res_slot;
			hit_out_q     <= res_hit;
			fill_q        <= res_fill;
			evict_valid_q <= res_evict_valid;
			evict_key_q   <= res_evict_key;
			status_q      <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot        = slot_q;
	assign hit         = hit_out_q;
	assign fill_needed = fill_q;
	assign evict_valid = evict_valid_q;
	assign evict_key   = evict_key_q;
	assign status      = status_q;

endmodule
`default_nettype wire

@@ hdl/key_register_cache_aging_lru.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Commit, direct registers, hits and the no-free-slot case pass from input
//   transfer through the lookup and finish states to output valid; a miss
//   adds victim search steps between them (at most two aging steps).
// One item at a time: a new input is taken only after the result is
//   registered, and finish waits while the output register is still full.
// Reset (arst_n low) empties all slots, clears ages and use marks.
// ----------------------------------------------------------------------------
// key_register_cache_aging_lru
// Fully associative key register cache with two-bit aging replacement.
// ----------------------------------------------------------------------------
module key_register_cache_aging_lru
	import krc_pkg::*;
#(
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
	parameter int FIRST_SLOT  = FIRST_SLOT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OP_W-1:0]  op,
	input  wire logic [KEY_W-1:0] key_addr,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [SLOT_W-1:0]     slot,
	output logic                  hit,
	output logic                  fill_needed,
	output logic                  evict_valid,
	output logic [KEY_W-1:0]      evict_key,
	output logic                  status
);

	krc_cmd_t  cmd;
	krc_stat_t stat;

	krc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	krc_dpath #(
		.CACHE_SLOTS (CACHE_SLOTS),
		.FIRST_SLOT  (FIRST_SLOT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.key_addr    (key_addr),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.slot        (slot),
		.hit         (hit),
		.fill_needed (fill_needed),
		.evict_valid (evict_valid),
		.evict_key   (evict_key),
		.status      (status)
	);

	// one item in flight: no transfer right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (slot == '0 && !hit && !fill_needed && !evict_valid))
		else $error("no_free_slot result carries a slot");

	a_fill_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (fill_needed || evict_valid)) |-> (!hit && !status))
		else $error("fill or eviction reported on a hit");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evict_valid) |-> (evict_key == '0))
		else $error("eviction key without eviction");

endmodule
`default_nettype wire
